// ===== hw/rtl/acbc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// acbc_pkg
// Shared types, constants and AES helper functions for the CBC decryptor.
// ----------------------------------------------------------------------------
package acbc_pkg;

    localparam int NumRounds = 10;
    localparam int CfgIdxW = 2;
    localparam int QueueDepth = 2;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] RegKeyHigh = 2'd0;
    localparam logic [CfgIdxW-1:0] RegKeyLow = 2'd1;
    localparam logic [CfgIdxW-1:0] RegIvHigh = 2'd2;
    localparam logic [CfgIdxW-1:0] RegIvLow = 2'd3;

    // classified block handed from the front end to the cipher core
    typedef struct packed {
        logic [127:0] cipher;
        logic [127:0] chain;
        logic         final_blk;
    } acbc_job_t;

    typedef struct packed {
        logic [127:0] plain;
        logic         final_blk;
    } acbc_res_t;

    // key expansion sequencer state
    typedef enum logic [1:0] {
        KX_IDLE,
        KX_RUN
    } acbc_kx_state_t;

    function automatic logic [7:0] xt(input logic [7:0] a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
        logic [7:0] a2;
        logic [7:0] a4;
        logic [7:0] a8;
        a2 = xt(a);
        a4 = xt(a2);
        a8 = xt(a4);
        gmul = (b[0] ? a : 8'h00) ^ (b[1] ? a2 : 8'h00) ^ (b[2] ? a4 : 8'h00)
            ^ (b[3] ? a8 : 8'h00);
    endfunction

    localparam logic [2047:0] SboxTab = {
        128'h16bb54b00f2d99416842e6bf0d89a18c,
        128'hdf2855cee9871e9b948ed9691198f8e1,
        128'h9e1dc186b95735610ef6034866b53e70,
        128'h8a8bbd4b1f74dde8c6b4a61c2e2578ba,
        128'h08ae7a65eaf4566ca94ed58d6d37c8e7,
        128'h79e4959162acd3c25c2406490a3a32e0,
        128'hdb0b5ede14b8ee4688902a22dc4f8160,
        128'h73195d643d7ea7c41744975fec130ccd,
        128'hd2f3ff1021dab6bcf5389d928f40a351,
        128'ha89f3c507f02f94585334d43fbaaefd0,
        128'hcf584c4a39becb6a5bb1fc20ed00d153,
        128'h842fe329b3d63b52a05a6e1b1a2c8309,
        128'h75b227ebe28012079a059618c323c704,
        128'h1531d871f1e5a534ccf73f362693fdb7,
        128'hc072a49cafa2d4adf04759fa7dc982ca,
        128'h76abd7fe2b670130c56f6bf27b777c63
    };

    localparam logic [2047:0] InvSboxTab = {
        128'h7d0c2155631469e126d677ba7e042b17,
        128'h619953833cbbebc8b0f52aae4d3be0a0,
        128'hef9cc9939f7ae52d0d4ab519a97f5160,
        128'h5fec8027591012b131c7078833a8dd1f,
        128'hf45acd78fec0db9a2079d2c64b3e56fc,
        128'h1bbe18aa0e62b76f89c5291d711af147,
        128'h6edf751ce837f9e28535ade72274ac96,
        128'h73e6b4f0cecff297eadc674f4111913a,
        128'h6b8a130103bdafc1020f3fca8f1e2cd0,
        128'h0645b3b80558e4f70ad3bc8c00abd890,
        128'h849d8da75746155edab9edfd5048706c,
        128'h92b6655dcc5ca4d41698688664f6f872,
        128'h25d18b6d49a25b76b224d92866a12e08,
        128'h4ec3fa420b954cee3d23c2a632947b54,
        128'hcbe9dec444438e3487ff2f9b8239e37c,
        128'hfbd7f3819ea340bf38a53630d56a0952
    };

    function automatic logic [7:0] sbox(input logic [7:0] x);
        sbox = SboxTab[{x, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        inv_sbox = InvSboxTab[{x, 3'b000} +: 8];
    endfunction

endpackage : acbc_pkg
`default_nettype wire

// ===== hw/rtl/aes128_cbc_decrypt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aes128_cbc_decrypt
// AES-128 CBC decryption with queue-style ports on both sides.
// ----------------------------------------------------------------------------
// Each block passes through the round unit as one load plus ten inverse
// rounds on a single shared round datapath, and the next block is taken
// only as the previous one finishes its last round; a two-entry job queue
// in front and a two-entry result queue behind let input and output stall
// independently. A write to a key register rebuilds the round keys; no block
// starts meanwhile. After reset the round keys of the all-zero key are built
// the same way. Chaining restarts from the IV after a block marked final.
module aes128_cbc_decrypt
    import acbc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [63:0]        cipher_high,
    input  wire logic [63:0]        cipher_low,
    input  wire logic               final_in,
    output logic                    empty,
    input  wire logic               pop,
    output logic [63:0]             plain_high,
    output logic [63:0]             plain_low,
    output logic                    final_out,
    output logic [7:0]              pad_byte,
    input  wire logic               cfg_we,
    input  wire logic [CfgIdxW-1:0] cfg_index,
    input  wire logic [63:0]        cfg_data
);

    logic [127:0] iv_reg;
    logic         key_we;
    logic         key_busy;
    logic [3:0]   rk_idx;
    logic [127:0] rk;
    logic [127:0] rk_last;
    acbc_job_t    job;
    logic         job_valid, job_take;
    acbc_res_t    res;
    logic         res_valid, res_take;

    // iv registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            iv_reg <= '0;
        else if (cfg_we && cfg_index == RegIvHigh)
            iv_reg[127:64] <= cfg_data;
        else if (cfg_we && cfg_index == RegIvLow)
            iv_reg[63:0] <= cfg_data;
    end

    assign key_we = cfg_we && (cfg_index == RegKeyHigh || cfg_index == RegKeyLow);

    acbc_keyexp u_keyexp (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_we       (key_we),
        .key_sel_high (cfg_index == RegKeyHigh),
        .key_data     (cfg_data),
        .rk_idx       (rk_idx),
        .rk           (rk),
        .rk_last      (rk_last),
        .busy         (key_busy)
    );

    acbc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .cipher    ({cipher_high, cipher_low}),
        .final_in  (final_in),
        .iv        (iv_reg),
        .job_valid (job_valid),
        .job_take  (job_take),
        .job       (job)
    );

    acbc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_take  (job_take),
        .job       (job),
        .key_busy  (key_busy),
        .rk_idx    (rk_idx),
        .rk        (rk),
        .rk_last   (rk_last),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    // result transfer
    assign empty      = !res_valid;
    assign res_take   = pop && res_valid;
    assign plain_high = res.plain[127:64];
    assign plain_low  = res.plain[63:0];
    assign final_out  = res.final_blk;
    assign pad_byte   = res.final_blk ? res.plain[7:0] : 8'h00;

    // no block starts while round keys are rebuilt
    a_no_start_in_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
        key_busy |-> !job_take)
        else $error("block started during key expansion");

    // a job is only taken from a non-empty queue
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |-> job_valid)
        else $error("job taken from empty queue");

    // pad byte is zero on non-final results
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !final_out) |-> (pad_byte == 8'h00))
        else $error("pad byte on non-final block");

endmodule : aes128_cbc_decrypt
`default_nettype wire

// ===== hw/rtl/acbc_keyexp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// acbc_keyexp
// Key register bank and sequential AES-128 round key expansion, one round
// key per cycle (a key write restarts it); keys in flops, read by index.
// ----------------------------------------------------------------------------
module acbc_keyexp
    import acbc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         key_we,
    input  wire logic         key_sel_high,
    input  wire logic [63:0]  key_data,
    input  wire logic [3:0]   rk_idx,
    output logic [127:0]      rk,
    output logic [127:0]      rk_last,
    output logic              busy
);

    logic [127:0] key_reg;
    logic [127:0] rk_reg [NumRounds+1];
    logic [127:0] cur_reg;
    logic [3:0]   cnt_reg;
    logic [7:0]   rcon_reg;
    acbc_kx_state_t state_reg, state_next;
    logic [127:0] nxt_key;
    logic [31:0]  tw;
    logic [31:0]  w0, w1, w2, w3;

    // next round key from the current one
    always_comb
    begin
        tw = {sbox(cur_reg[23:16]), sbox(cur_reg[15:8]), sbox(cur_reg[7:0]),
            sbox(cur_reg[31:24])} ^ {rcon_reg, 24'h0};
        w0 = cur_reg[127:96] ^ tw;
        w1 = cur_reg[95:64] ^ w0;
        w2 = cur_reg[63:32] ^ w1;
        w3 = cur_reg[31:0] ^ w2;
        nxt_key = {w0, w1, w2, w3};
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            KX_IDLE:
            begin
                if (key_we)
                    state_next = KX_RUN;
            end
            KX_RUN:
            begin
                if (key_we)
                    state_next = KX_RUN;
                else if (cnt_reg == 4'(NumRounds))
                    state_next = KX_IDLE;
            end
            default: state_next = KX_IDLE;
        endcase
    end

    // busy while a restart is pending or a rebuild runs
    always_comb
    begin
        case (state_reg)
            KX_RUN:  busy = 1'b1;
            default: busy = key_we;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= KX_RUN;
            key_reg   <= '0;
            cur_reg   <= '0;
            cnt_reg   <= 4'd0;
            rcon_reg  <= 8'h01;
        end
        else
        begin
            state_reg <= state_next;
            if (key_we)
            begin
                if (key_sel_high)
                begin
                    key_reg[127:64] <= key_data;
                    cur_reg <= {key_data, key_reg[63:0]};
                end
                else
                begin
                    key_reg[63:0] <= key_data;
                    cur_reg <= {key_reg[127:64], key_data};
                end
                cnt_reg  <= 4'd0;
                rcon_reg <= 8'h01;
            end
            else if (state_reg == KX_RUN)
            begin
                cur_reg  <= nxt_key;
                cnt_reg  <= cnt_reg + 4'd1;
                rcon_reg <= xt(rcon_reg);
            end
        end
    end

    // round key storage, written as the sequencer passes each index
    always_ff @(posedge clk)
    begin
        if (state_reg == KX_RUN && !key_we)
            rk_reg[cnt_reg] <= cur_reg;
    end

    assign rk      = rk_reg[rk_idx];
    // last round key on its own port, used when a block is loaded
    assign rk_last = rk_reg[NumRounds];

endmodule : acbc_keyexp
`default_nettype wire

// ===== hw/rtl/acbc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// acbc_front
// Accepts ciphertext blocks, picks the chaining value (IV or previous
// block) and queues the job for the cipher core.
// ----------------------------------------------------------------------------
module acbc_front
    import acbc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire logic [127:0] cipher,
    input  wire logic         final_in,
    input  wire logic [127:0] iv,
    output logic              job_valid,
    input  wire logic         job_take,
    output acbc_job_t         job
);

    logic [127:0] prev_reg;
    logic         first_reg;
    acbc_job_t    q_reg [QueueDepth];
    logic         wp_reg, rp_reg;
    logic [1:0]   cnt_reg;
    logic         do_push;

    assign full      = (cnt_reg == 2'(QueueDepth));
    assign do_push   = push && !full;
    assign job_valid = (cnt_reg != 2'd0);
    assign job       = q_reg[rp_reg];

    // chaining state and queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            first_reg <= 1'b1;
            wp_reg    <= 1'b0;
            rp_reg    <= 1'b0;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                prev_reg  <= cipher;
                first_reg <= final_in;
                wp_reg    <= ~wp_reg;
            end
            if (job_take)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(do_push) - 2'(job_take);
        end
    end

    // queue entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wp_reg].cipher    <= cipher;
            q_reg[wp_reg].chain     <= first_reg ? iv : prev_reg;
            q_reg[wp_reg].final_blk <= final_in;
        end
    end

endmodule : acbc_front
`default_nettype wire

// ===== hw/rtl/acbc_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// acbc_core
// Iterative AES-128 inverse cipher, one round per cycle (the last waits for
// room in the result queue), with chaining XOR and a two-entry result queue.
// ----------------------------------------------------------------------------
module acbc_core
    import acbc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         job_valid,
    output logic              job_take,
    input  acbc_job_t         job,
    input  wire logic         key_busy,
    output logic [3:0]        rk_idx,
    input  wire logic [127:0] rk,
    input  wire logic [127:0] rk_last,
    output logic              res_valid,
    input  wire logic         res_take,
    output acbc_res_t         res
);

    logic [127:0] st_reg;
    logic [127:0] chain_reg;
    logic         fin_reg;
    logic         run_reg;
    logic [3:0]   rnd_reg;
    acbc_res_t    q_reg [QueueDepth];
    logic         wp_reg, rp_reg;
    logic [1:0]   cnt_reg;
    logic [127:0] ss;
    logic [127:0] ark;
    logic [127:0] mixed;
    logic         done;
    logic         room;
    logic [7:0]   b [16];
    logic [7:0]   a0, a1, a2, a3;

    // round key index follows the round counter; the load uses the last key port
    assign rk_idx = rnd_reg;

    assign done  = run_reg && (rnd_reg == 4'd0);
    assign room  = (cnt_reg != 2'(QueueDepth)) || res_take;
    assign job_take = job_valid && !key_busy && (!run_reg || (done && room));

    // inverse shift rows and inverse sub bytes, then key add and inverse mix
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                b[r + 4 * ((c + r) % 4)] = inv_sbox(st_reg[127 - 8 * (r + 4 * c) -: 8]);
            end
        end
        for (int i = 0; i < 16; i++)
            ss[127 - 8 * i -: 8] = b[i];
        ark = ss ^ rk;
        for (int c = 0; c < 4; c++)
        begin
            a0 = ark[127 - 32 * c -: 8];
            a1 = ark[119 - 32 * c -: 8];
            a2 = ark[111 - 32 * c -: 8];
            a3 = ark[103 - 32 * c -: 8];
            mixed[127 - 32 * c -: 8] = gmul(a0, 4'd14) ^ gmul(a1, 4'd11)
                ^ gmul(a2, 4'd13) ^ gmul(a3, 4'd9);
            mixed[119 - 32 * c -: 8] = gmul(a0, 4'd9) ^ gmul(a1, 4'd14)
                ^ gmul(a2, 4'd11) ^ gmul(a3, 4'd13);
            mixed[111 - 32 * c -: 8] = gmul(a0, 4'd13) ^ gmul(a1, 4'd9)
                ^ gmul(a2, 4'd14) ^ gmul(a3, 4'd11);
            mixed[103 - 32 * c -: 8] = gmul(a0, 4'd11) ^ gmul(a1, 4'd13)
                ^ gmul(a2, 4'd9) ^ gmul(a3, 4'd14);
        end
    end

    // round sequencing and result queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            rnd_reg <= 4'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (job_take)
            begin
                run_reg <= 1'b1;
                rnd_reg <= 4'(NumRounds - 1);
            end
            else if (done && room)
                run_reg <= 1'b0;
            else if (run_reg && rnd_reg != 4'd0)
                rnd_reg <= rnd_reg - 4'd1;
            if (done && room)
                wp_reg <= ~wp_reg;
            if (res_take)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(done && room) - 2'(res_take);
        end
    end

    // datapath state
    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            st_reg    <= job.cipher ^ rk_last;
            chain_reg <= job.chain;
            fin_reg   <= job.final_blk;
        end
        else if (run_reg && rnd_reg != 4'd0)
            st_reg <= mixed;
        if (done && room)
        begin
            q_reg[wp_reg].plain     <= ark ^ chain_reg;
            q_reg[wp_reg].final_blk <= fin_reg;
        end
    end

    assign res_valid = (cnt_reg != 2'd0);
    assign res       = q_reg[rp_reg];

endmodule : acbc_core
`default_nettype wire

// ===== sim/aes128_cbc_decrypt_tb.sv =====
// ----------------------------------------------------------------------------
// aes128_cbc_decrypt_tb
// Checks the CBC decryptor against its own AES-128 inverse cipher and chaining
// model. Blocks are sent through a queue-style input and results are collected
// through a queue-style output. Both sides idle at random, and the receiver
// holds off once so that the block fills up and stalls its input. The key and
// IV are changed between phases, sometimes while a message is still open.
// ----------------------------------------------------------------------------
module aes128_cbc_decrypt_tb;
    import acbc_pkg::*;

    typedef struct {
        logic [63:0] ch;
        logic [63:0] cl;
        logic        fin;
    } cblock_t;

    typedef struct {
        logic [63:0] ph;
        logic [63:0] pl;
        logic        fin;
        logic [7:0]  pad;
    } pblock_t;

    localparam int CycleLimit = 400000;
    localparam int DrainCycles = 40;
    localparam int HoldCycles = 300;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [63:0]        cipher_high = '0;
    logic [63:0]        cipher_low = '0;
    logic               final_in = 1'b0;
    logic               empty;
    logic               pop = 1'b0;
    logic [63:0]        plain_high;
    logic [63:0]        plain_low;
    logic               final_out;
    logic [7:0]         pad_byte;
    logic               cfg_we = 1'b0;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [63:0]        cfg_data = '0;

    aes128_cbc_decrypt dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .cipher_high(cipher_high), .cipher_low(cipher_low), .final_in(final_in),
        .empty(empty), .pop(pop), .plain_high(plain_high), .plain_low(plain_low),
        .final_out(final_out), .pad_byte(pad_byte),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // model state
    logic [7:0]   fwd_sub [256];
    logic [7:0]   inv_sub [256];
    logic [127:0] round_key [11];
    logic [63:0]  mdl_key_hi = '0, mdl_key_lo = '0, mdl_iv_hi = '0, mdl_iv_lo = '0;
    logic [127:0] chain_block = '0;
    logic         msg_start = 1'b1;

    cblock_t pending_blocks [$];
    pblock_t expected_plain [$];
    int      send_idle = 0;
    int      recv_idle = 0;
    bit      hold_req = 0;
    int      hold_cnt = 0;
    int      errors = 0;
    int      sent_cnt = 0;
    int      recv_cnt = 0;
    int      final_cnt = 0;
    int      cycles = 0;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[0]) r = r ^ a;
            a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
            b = b >> 1;
        end
        return r;
    endfunction

    function automatic logic [7:0] rol8(input logic [7:0] x, input int n);
        return (x << n) | (x >> (8 - n));
    endfunction

    // substitution tables from the field inverse and the affine map
    task automatic build_sub_tables();
        logic [7:0] r, base, s;
        int e;
        for (int x = 0; x < 256; x++) begin
            r = 8'h01;
            base = x[7:0];
            e = 254;
            while (e != 0) begin
                if (e & 1) r = gf_mul(r, base);
                base = gf_mul(base, base);
                e = e >> 1;
            end
            s = r ^ rol8(r, 1) ^ rol8(r, 2) ^ rol8(r, 3) ^ rol8(r, 4) ^ 8'h63;
            fwd_sub[x] = s;
            inv_sub[s] = x[7:0];
        end
    endtask

    // round keys from the two key registers
    task automatic expand_round_keys();
        logic [31:0] w [44];
        logic [31:0] t;
        logic [7:0]  rc;
        rc = 8'h01;
        w[0] = mdl_key_hi[63:32];
        w[1] = mdl_key_hi[31:0];
        w[2] = mdl_key_lo[63:32];
        w[3] = mdl_key_lo[31:0];
        for (int i = 4; i < 44; i++) begin
            t = w[i-1];
            if ((i % 4) == 0) begin
                t = {t[23:0], t[31:24]};
                t = {fwd_sub[t[31:24]], fwd_sub[t[23:16]], fwd_sub[t[15:8]],
                     fwd_sub[t[7:0]]};
                t = t ^ {rc, 24'h0};
                rc = gf_mul(rc, 8'h02);
            end
            w[i] = w[i-4] ^ t;
        end
        for (int r = 0; r <= 10; r++)
            round_key[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    endtask

    function automatic logic [127:0] inv_cipher(input logic [127:0] c);
        logic [7:0]   s [16];
        logic [7:0]   t [16];
        logic [7:0]   a0, a1, a2, a3;
        logic [127:0] res;
        for (int i = 0; i < 16; i++) s[i] = c[127-8*i -: 8] ^ round_key[10][127-8*i -: 8];
        for (int r = 9; r >= 0; r--) begin
            for (int col = 0; col < 4; col++)
                for (int row = 0; row < 4; row++)
                    t[row + 4*((col + row) % 4)] = inv_sub[s[row + 4*col]];
            for (int i = 0; i < 16; i++) s[i] = t[i] ^ round_key[r][127-8*i -: 8];
            if (r != 0) begin
                for (int col = 0; col < 4; col++) begin
                    a0 = s[4*col]; a1 = s[4*col+1]; a2 = s[4*col+2]; a3 = s[4*col+3];
                    s[4*col]   = gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11) ^ gf_mul(a2, 8'd13)
                        ^ gf_mul(a3, 8'd9);
                    s[4*col+1] = gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14) ^ gf_mul(a2, 8'd11)
                        ^ gf_mul(a3, 8'd13);
                    s[4*col+2] = gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9) ^ gf_mul(a2, 8'd14)
                        ^ gf_mul(a3, 8'd11);
                    s[4*col+3] = gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13) ^ gf_mul(a2, 8'd9)
                        ^ gf_mul(a3, 8'd14);
                end
            end
        end
        for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
        return res;
    endfunction

    // plaintext for one accepted block, advancing the chaining state
    task automatic predict_plain(input cblock_t b);
        logic [127:0] p;
        pblock_t      e;
        p = inv_cipher({b.ch, b.cl});
        p = p ^ (msg_start ? {mdl_iv_hi, mdl_iv_lo} : chain_block);
        chain_block = {b.ch, b.cl};
        msg_start = b.fin;
        e.ph = p[127:64];
        e.pl = p[63:0];
        e.fin = b.fin;
        e.pad = b.fin ? p[7:0] : 8'h00;
        expected_plain.push_back(e);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on result %0d: %s got %h expected %h", recv_cnt, what, got, want);
        errors++;
    endtask

    // one register write per clock edge; caller lowers cfg_we afterwards
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            RegKeyHigh: begin mdl_key_hi = val; expand_round_keys(); end
            RegKeyLow:  begin mdl_key_lo = val; expand_round_keys(); end
            RegIvHigh:  mdl_iv_hi = val;
            RegIvLow:   mdl_iv_lo = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic load_settings(input logic [63:0] kh, input logic [63:0] kl,
                                 input logic [63:0] ih, input logic [63:0] il);
        write_reg(RegKeyHigh, kh);
        write_reg(RegKeyLow, kl);
        write_reg(RegIvHigh, ih);
        write_reg(RegIvLow, il);
        cfg_we <= 1'b0;
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic add_block(input logic [63:0] ch, input logic [63:0] cl, input logic fin);
        cblock_t b;
        b.ch = ch;
        b.cl = cl;
        b.fin = fin;
        pending_blocks.push_back(b);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // random messages of 1 to 6 blocks, about n blocks in all
    task automatic add_messages(input int n);
        int len;
        while (n > 0) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) add_block(rand64(), rand64(), i == len - 1);
            n -= len;
        end
    endtask

    task automatic drain();
        while (pending_blocks.size() != 0 || expected_plain.size() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // input driver
    always @(posedge clk) begin
        if (push && !full) begin
            predict_plain(pending_blocks.pop_front());
            sent_cnt++;
        end
        if (rst_n && pending_blocks.size() != 0 && $urandom_range(99) >= send_idle) begin
            push <= 1'b1;
            cipher_high <= pending_blocks[0].ch;
            cipher_low <= pending_blocks[0].cl;
            final_in <= pending_blocks[0].fin;
        end else begin
            push <= 1'b0;
        end
    end

    // result monitor
    always @(posedge clk) begin
        pblock_t e;
        if (pop && !empty) begin
            if (expected_plain.size() == 0) begin
                $display("unexpected result transfer: %h %h", plain_high, plain_low);
                errors++;
            end else begin
                e = expected_plain.pop_front();
                if (plain_high !== e.ph) report_mismatch("plain_high", plain_high, e.ph);
                if (plain_low !== e.pl) report_mismatch("plain_low", plain_low, e.pl);
                if (final_out !== e.fin)
                    report_mismatch("final_out", 64'(final_out), 64'(e.fin));
                if (pad_byte !== e.pad)
                    report_mismatch("pad_byte", 64'(pad_byte), 64'(e.pad));
                if (e.fin) final_cnt++;
            end
            recv_cnt++;
        end
        if (hold_req && hold_cnt == 0) hold_cnt = HoldCycles;
        if (hold_cnt > 0) begin
            hold_cnt--;
            pop <= 1'b0;
        end else begin
            pop <= rst_n && ($urandom_range(99) >= recv_idle);
        end
    end

    // run limit
    always @(posedge clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("aes128_cbc_decrypt_tb NOT OK");
            $finish;
        end
    end

    initial begin
        build_sub_tables();
        expand_round_keys();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (DrainCycles) @(posedge clk);

        // directed: standard test key and vector, field extremes, open message
        load_settings(64'h0001020304050607, 64'h08090a0b0c0d0e0f, '0, '0);
        add_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1);
        add_block('0, '0, 1'b1);
        add_block('1, '1, 1'b1);
        add_block('1, '0, 1'b0);
        add_block('0, '1, 1'b0);
        add_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1);
        for (int i = 0; i < 8; i++) add_block(rand64(), rand64(), i == 7);
        add_block(rand64(), rand64(), 1'b0);
        drain();

        // key and iv changed while a message is open: chaining must continue
        load_settings('0, '0, '0, '0);
        add_block(rand64(), rand64(), 1'b1);
        add_block('0, '0, 1'b1);
        add_block(rand64(), rand64(), 1'b0);
        drain();

        // slow sender, busy receiver, with a long receiver hold-off
        send_idle = 16;
        recv_idle = 75;
        load_settings('1, '1, '1, '1);
        hold_req = 1;
        add_messages(40);
        repeat (HoldCycles / 2) @(posedge clk);
        hold_req = 0;
        add_messages(100);
        add_block(rand64(), rand64(), 1'b0);
        drain();

        send_idle = 75;
        recv_idle = 16;
        load_settings(rand64(), rand64(), rand64(), rand64());
        add_messages(130);
        drain();

        send_idle = 0;
        recv_idle = 0;
        load_settings(rand64(), rand64(), '0, rand64());
        add_messages(130);
        drain();

        if (expected_plain.size() != 0) begin
            $display("%0d expected results never arrived", expected_plain.size());
            errors++;
        end
        $display("sent %0d cipher blocks, checked %0d plaintext blocks (%0d message ends)",
                 sent_cnt, recv_cnt, final_cnt);
        $display("five key/iv settings, three idle patterns, one long output stall");
        if (errors == 0)
            $display("aes128_cbc_decrypt_tb OK");
        else
            $display("aes128_cbc_decrypt_tb NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/acbc_pkg.sv
hw/rtl/acbc_keyexp.sv
hw/rtl/acbc_front.sv
hw/rtl/acbc_core.sv
hw/rtl/aes128_cbc_decrypt.sv
sim/aes128_cbc_decrypt_tb.sv
